>>> hw/rtl/pair_distance_difference_histogram_core_defines.svh
// Assertion macros shared by the pair distance difference histogram RTL.
// Include after the timescale line; the macros use clk_i and rst_ni of the including module.
`ifndef PAIR_DISTANCE_DIFFERENCE_HISTOGRAM_CORE_DEFINES_SVH
`define PAIR_DISTANCE_DIFFERENCE_HISTOGRAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every rising edge of clk_i outside reset.
`define PDDH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true at a rising edge of clk_i outside reset.
`define PDDH_ASSERT_NEVER(name, cond, msg) \
  `PDDH_ASSERT(name, !(cond), msg)
`else
`define PDDH_ASSERT(name, prop, msg)
`define PDDH_ASSERT_NEVER(name, cond, msg)
`endif

`endif

>>> hw/rtl/pddh_pkg.sv
// Package of the pair distance difference histogram: field widths, codes and the
// command and status types between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package pddh_pkg;

  // Fixed field widths of the channels.
  localparam int CMD_W       = 2;
  localparam int COORD_W     = 6;
  localparam int PIX_FIELD_W = 16;
  localparam int BIN_FIELD_W = 13;
  localparam int SUM_FIELD_W = 48;
  localparam int COUNT_W     = 32;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 7;

  // Register indexes of the configuration port.
  localparam logic [CFG_AW-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_GRID_COLS = 2'd1;

  // Reset value of both grid side registers.
  localparam logic [CFG_DW-1:0] SIDE_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_PAIR = 2'd1,
    CMD_READ = 2'd2
  } pddh_cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PIX_B,
    ST_BIN_RD,
    ST_BIN_WR,
    ST_RD_OUT
  } pddh_state_e;

  typedef struct packed {
    logic latch_item;
    logic img_wr;
    logic img_rd_a;
    logic img_rd_b;
    logic cap_pa;
    logic cap_diff;
    logic bin_rd_pair;
    logic bin_rd_query;
    logic bin_wr_acc;
    logic clr_step;
    logic out_load;
  } pddh_cmd_t;

  typedef struct packed {
    pddh_cmd_e cmd;
    logic      pair_ok;
    logic      clr_last;
  } pddh_status_t;

endpackage

>>> hw/rtl/pddh_ifs.sv
// Channel interfaces of the pair distance difference histogram: item input,
// result output and configuration write. Depends on pddh_pkg.
`timescale 1ns / 1ps

interface pddh_in_if;
  import pddh_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [COORD_W-1:0]     row_a;
  logic [COORD_W-1:0]     col_a;
  logic [COORD_W-1:0]     row_b;
  logic [COORD_W-1:0]     col_b;
  logic [PIX_FIELD_W-1:0] pixel_value;
  logic [BIN_FIELD_W-1:0] bin_index;

  modport source (output valid, cmd, row_a, col_a, row_b, col_b, pixel_value, bin_index,
                  input ready);
  modport sink (input valid, cmd, row_a, col_a, row_b, col_b, pixel_value, bin_index,
                output ready);
endinterface

interface pddh_out_if;
  import pddh_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SUM_FIELD_W-1:0] bin_sum;
  logic [COUNT_W-1:0]     pair_count;

  modport source (output valid, bin_sum, pair_count, input ready);
  modport sink (input valid, bin_sum, pair_count, output ready);
endinterface

interface pddh_cfg_if;
  import pddh_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> hw/rtl/pddh_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module pddh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/pddh_ctrl.sv
// Controller of the pair distance difference histogram: sequences the clearing pass,
// item decode, pixel reads and the bin read-modify-write. Depends on pddh_pkg.
`timescale 1ns / 1ps
`include "pair_distance_difference_histogram_core_defines.svh"

module pddh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pddh_pkg::pddh_status_t status_i,
  output pddh_pkg::pddh_cmd_t    cmd_o
);
  import pddh_pkg::*;

  pddh_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.cmd)
          CMD_PAIR: state_d = status_i.pair_ok ? ST_PIX_B : ST_IDLE;
          CMD_READ: state_d = ST_RD_OUT;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_PIX_B:  state_d = ST_BIN_RD;
      ST_BIN_RD: state_d = ST_BIN_WR;
      ST_BIN_WR: state_d = ST_IDLE;
      ST_RD_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.latch_item = in_valid_i;
      end
      ST_EXEC: begin
        case (status_i.cmd)
          CMD_LOAD: cmd_o.img_wr       = 1'b1;
          CMD_PAIR: cmd_o.img_rd_a     = status_i.pair_ok;
          CMD_READ: cmd_o.bin_rd_query = 1'b1;
          default:  cmd_o.img_wr       = 1'b0;
        endcase
      end
      ST_PIX_B: begin
        cmd_o.img_rd_b = 1'b1;
        cmd_o.cap_pa   = 1'b1;
      end
      ST_BIN_RD: begin
        cmd_o.cap_diff    = 1'b1;
        cmd_o.bin_rd_pair = 1'b1;
      end
      ST_BIN_WR: cmd_o.bin_wr_acc = 1'b1;
      ST_RD_OUT: cmd_o.out_load = slot_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PDDH_ASSERT(a_accept_to_exec, (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC), "accepted item was not decoded in the next cycle")
  `PDDH_ASSERT_NEVER(a_no_result_overwrite, cmd_o.out_load && out_valid_q && !out_ready_i, "result register loaded while still holding an untaken result")
  `PDDH_ASSERT(a_clear_runs_through, (state_q == ST_CLEAR && !status_i.clr_last) |=> (state_q == ST_CLEAR), "clearing pass left before the last bin")
  `PDDH_ASSERT(a_bin_read_then_write, (state_q == ST_BIN_RD) |=> cmd_o.bin_wr_acc, "bin read not followed by its write back")

endmodule

>>> hw/rtl/pddh_dp.sv
// Datapath of the pair distance difference histogram: item and grid registers,
// image and bin memories, distance and difference arithmetic, pair counter.
// Depends on pddh_pkg and pddh_ram.
`timescale 1ns / 1ps

module pddh_dp #(
  parameter int MAX_SIDE   = 64,
  parameter int PIXEL_BITS = 16,
  parameter int SUM_BITS   = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pddh_pkg::pddh_cmd_t               cmd_i,
  output pddh_pkg::pddh_status_t            status_o,
  input  logic [pddh_pkg::CMD_W-1:0]        in_cmd_i,
  input  logic [pddh_pkg::COORD_W-1:0]      in_row_a_i,
  input  logic [pddh_pkg::COORD_W-1:0]      in_col_a_i,
  input  logic [pddh_pkg::COORD_W-1:0]      in_row_b_i,
  input  logic [pddh_pkg::COORD_W-1:0]      in_col_b_i,
  input  logic [pddh_pkg::PIX_FIELD_W-1:0]  in_pixel_i,
  input  logic [pddh_pkg::BIN_FIELD_W-1:0]  in_bin_i,
  input  logic                              cfg_we_i,
  input  logic [pddh_pkg::CFG_AW-1:0]       cfg_addr_i,
  input  logic [pddh_pkg::CFG_DW-1:0]       cfg_data_i,
  output logic [pddh_pkg::SUM_FIELD_W-1:0]  bin_sum_o,
  output logic [pddh_pkg::COUNT_W-1:0]      pair_count_o
);
  import pddh_pkg::*;

  localparam int IMG_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int BIN_DEPTH = 2 * (MAX_SIDE - 1) * (MAX_SIDE - 1) + 1;
  localparam int BIN_AW    = $clog2(BIN_DEPTH);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int PROD_W    = COORD_W + SIDE_W + 1;
  localparam int ACC_W     = (SUM_BITS > PIXEL_BITS ? SUM_BITS : PIXEL_BITS) + 1;
  localparam logic [BIN_AW-1:0] BIN_LAST  = BIN_AW'(BIN_DEPTH - 1);
  localparam logic [ACC_W-1:0]  SUM_MAX_W = (ACC_W'(1) << SUM_BITS) - ACC_W'(1);

  // A side of zero acts as one, a side above the grid limit as the limit.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DW-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      return SIDE_W'(MAX_SIDE);
    end
    return SIDE_W'(v);
  endfunction

  // Latched item.
  logic [CMD_W-1:0]       item_cmd_q;
  logic [COORD_W-1:0]     ra_q, ca_q, rb_q, cb_q;
  logic [PIX_FIELD_W-1:0] item_pix_q;
  logic [BIN_FIELD_W-1:0] item_bin_q;

  // Grid registers and control state.
  logic [CFG_DW-1:0]  rows_q, rows_d, cols_q, cols_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [BIN_AW-1:0]  clr_cnt_q, clr_cnt_d;

  // Pipeline payload.
  logic [PIXEL_BITS-1:0]  pa_q, diff_q;
  logic [SUM_FIELD_W-1:0] bin_sum_q;
  logic [COUNT_W-1:0]     pair_count_q;

  logic [SIDE_W-1:0]      rows_c, cols_c;
  logic                   in_grid_a, in_grid_b;
  logic [PROD_W-1:0]      addr_a_w, addr_b_w;
  logic [COORD_W-1:0]     dr, dc;
  logic [BIN_FIELD_W-1:0] sq_dist;
  logic                   bin_ok;
  logic [PIXEL_BITS-1:0]  img_rdata, pix_diff;
  logic [SUM_BITS-1:0]    bin_rdata, acc_sat, bin_wdata;
  logic [ACC_W-1:0]       acc_w;
  logic [BIN_AW-1:0]      bin_raddr, bin_waddr;

  assign rows_c    = clamp_side(rows_q);
  assign cols_c    = clamp_side(cols_q);
  assign in_grid_a = (32'(ra_q) < 32'(rows_c)) && (32'(ca_q) < 32'(cols_c));
  assign in_grid_b = (32'(rb_q) < 32'(rows_c)) && (32'(cb_q) < 32'(cols_c));
  assign addr_a_w  = PROD_W'(ra_q) * PROD_W'(cols_c) + PROD_W'(ca_q);
  assign addr_b_w  = PROD_W'(rb_q) * PROD_W'(cols_c) + PROD_W'(cb_q);

  assign dr      = (ra_q > rb_q) ? ra_q - rb_q : rb_q - ra_q;
  assign dc      = (ca_q > cb_q) ? ca_q - cb_q : cb_q - ca_q;
  assign sq_dist = BIN_FIELD_W'(dr) * BIN_FIELD_W'(dr) + BIN_FIELD_W'(dc) * BIN_FIELD_W'(dc);
  assign bin_ok  = 32'(item_bin_q) < BIN_DEPTH;

  assign status_o.cmd      = pddh_cmd_e'(item_cmd_q);
  assign status_o.pair_ok  = (item_cmd_q == CMD_PAIR) && in_grid_a && in_grid_b &&
                             (sq_dist != '0) && (32'(sq_dist) < BIN_DEPTH);
  assign status_o.clr_last = (clr_cnt_q == BIN_LAST);

  // Image memory: one read per cycle, the two pixels of a pair go one after the other.
  pddh_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (IMG_DEPTH)
  ) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.img_wr && in_grid_a),
    .waddr_i (IMG_AW'(addr_a_w)),
    .wdata_i (PIXEL_BITS'(item_pix_q)),
    .re_i    (cmd_i.img_rd_a || cmd_i.img_rd_b),
    .raddr_i (cmd_i.img_rd_b ? IMG_AW'(addr_b_w) : IMG_AW'(addr_a_w)),
    .rdata_o (img_rdata)
  );

  assign pix_diff = (pa_q > img_rdata) ? pa_q - img_rdata : img_rdata - pa_q;

  // Saturating accumulation of the bin.
  assign acc_w   = ACC_W'(bin_rdata) + ACC_W'(diff_q);
  assign acc_sat = (acc_w > SUM_MAX_W) ? SUM_BITS'(SUM_MAX_W) : SUM_BITS'(acc_w);

  assign bin_raddr = cmd_i.bin_rd_query ? BIN_AW'(item_bin_q) : BIN_AW'(sq_dist);
  assign bin_waddr = cmd_i.clr_step ? clr_cnt_q : BIN_AW'(sq_dist);
  assign bin_wdata = cmd_i.clr_step ? '0 : acc_sat;

  pddh_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (BIN_DEPTH)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_step || cmd_i.bin_wr_acc),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .re_i    (cmd_i.bin_rd_query || cmd_i.bin_rd_pair),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GRID_ROWS: rows_d = cfg_data_i;
        REG_GRID_COLS: cols_d = cfg_data_i;
        default:       rows_d = rows_q;
      endcase
    end
  end

  assign count_d   = (cmd_i.bin_wr_acc && (count_q != '1)) ? count_q + COUNT_W'(1) : count_q;
  assign clr_cnt_d = cmd_i.clr_step ? clr_cnt_q + BIN_AW'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= SIDE_RESET;
      cols_q    <= SIDE_RESET;
      count_q   <= '0;
      clr_cnt_q <= '0;
    end else begin
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      count_q   <= count_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_cmd_q <= in_cmd_i;
      ra_q       <= in_row_a_i;
      ca_q       <= in_col_a_i;
      rb_q       <= in_row_b_i;
      cb_q       <= in_col_b_i;
      item_pix_q <= in_pixel_i;
      item_bin_q <= in_bin_i;
    end
    if (cmd_i.cap_pa) begin
      pa_q <= img_rdata;
    end
    if (cmd_i.cap_diff) begin
      diff_q <= pix_diff;
    end
    if (cmd_i.out_load) begin
      bin_sum_q    <= bin_ok ? SUM_FIELD_W'(bin_rdata) : '0;
      pair_count_q <= count_q;
    end
  end

  assign bin_sum_o    = bin_sum_q;
  assign pair_count_o = pair_count_q;

endmodule

>>> hw/rtl/pair_distance_difference_histogram_core.sv
// Pair distance difference histogram (sampled variogram by squared lag), top level.
// Using the block: items arrive on in_i, results leave on out_o, grid size on cfg_i.
// A load item (cmd 0) writes one pixel of the image at row_a, col_a.
// A pair item (cmd 1) adds |pixel(a) - pixel(b)| to the bin of the squared distance
// and counts the pair; pairs off the grid or of zero distance are dropped.
// A read item (cmd 2) returns one bin sum and the pair count as one result transfer.
// Throughput: the block takes one item at a time. A read passes through EXEC and
// RD_OUT, a load, a dropped pair or an unused command 3 through EXEC alone, and a
// counted pair through EXEC, PIX_B, BIN_RD and BIN_WR, set by the single read port
// of the image memory (the two pixels are fetched one after the other) and by the
// read-modify-write of the bin memory. A read loads the result register in RD_OUT.
// Reset: the grid registers return to 64 x 64, the pair count to zero, and a clearing
// pass zeroes one bin per cycle, 2*(MAX_SIDE-1)^2+1 bins (7939 at MAX_SIDE = 64),
// while in_i holds ready low. Configuration writes are taken at any time.
// Stall: a finished result sits in an output register; the next item is accepted
// while it waits, and only a later read waits for the register to empty.
`timescale 1ns / 1ps

module pair_distance_difference_histogram_core #(
  parameter int MAX_SIDE   = 64,
  parameter int PIXEL_BITS = 16,
  parameter int SUM_BITS   = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pddh_in_if.sink    in_i,
  pddh_out_if.source out_o,
  pddh_cfg_if.sink   cfg_i
);
  import pddh_pkg::*;

  // Command and status between the controller and the datapath.
  pddh_cmd_t    cmd;
  pddh_status_t status;

  // The grid registers always take a configuration transfer.
  assign cfg_i.ready = 1'b1;

  pddh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath owns the memories, the item register and the result register.
  pddh_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_cmd_i     (in_i.cmd),
    .in_row_a_i   (in_i.row_a),
    .in_col_a_i   (in_i.col_a),
    .in_row_b_i   (in_i.row_b),
    .in_col_b_i   (in_i.col_b),
    .in_pixel_i   (in_i.pixel_value),
    .in_bin_i     (in_i.bin_index),
    .cfg_we_i     (cfg_i.valid),
    .cfg_addr_i   (cfg_i.addr),
    .cfg_data_i   (cfg_i.data),
    .bin_sum_o    (out_o.bin_sum),
    .pair_count_o (out_o.pair_count)
  );

endmodule
